// ===== rtl/ntlm_pkg.sv =====
// Package for the NTLM chain walker: widths, register indexes, MD4 tables.
// No dependencies.
package ntlm_pkg;
  localparam int MaxText = 16;
  localparam int CharsetDepth = 256;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_CHARSET_SIZE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TABLE_OFFSET = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CHAIN_LENGTH = 3'd4;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K2  = 32'h5a827999;
  localparam logic [31:0] K3  = 32'h6ed9eba1;

  typedef enum logic {ACT_LOAD = 1'b0, ACT_WALK = 1'b1} action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPACE, ST_STEP, ST_LEN, ST_DIGIT, ST_TEXT, ST_ROUND, ST_SUM, ST_MOD, ST_OUT
  } state_t;

  function automatic logic [3:0] msg_word(input logic [5:0] j);
    logic [3:0] k;
    k = j[3:0];
    if (j < 6'd16) return k;
    else if (j < 6'd32) return {k[1:0], k[3:2]};
    else return {k[0], k[1], k[2], k[3]};
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] j);
    logic [4:0] s;
    s = 5'd3;
    if (j < 6'd16) begin
      case (j[1:0])
        2'd0: s = 5'd3; 2'd1: s = 5'd7; 2'd2: s = 5'd11; default: s = 5'd19;
      endcase
    end else if (j < 6'd32) begin
      case (j[1:0])
        2'd0: s = 5'd3; 2'd1: s = 5'd5; 2'd2: s = 5'd9; default: s = 5'd13;
      endcase
    end else begin
      case (j[1:0])
        2'd0: s = 5'd3; 2'd1: s = 5'd9; 2'd2: s = 5'd11; default: s = 5'd15;
      endcase
    end
    return s;
  endfunction
endpackage

// ===== rtl/ntlm_rainbow_chain_walker.sv =====
// NTLM rainbow chain walker: index->plaintext, MD4, reduction, under one sequencer.
// Depends on ntlm_pkg.
//
// channel  dir  tdata (low bit up)                                            tuser
// s_axis   in   charset_slot[7:0], charset_byte[15:8], start_index[79:16]     action
// m_axis   out  end_index[63:0]                                               -
// cfg      in   register index 0..4, write data 32 bits                       -
//
// Work: a load stores one charset byte. A chain step for plaintext length L runs a
// length search, then per character a restoring divide, a charset read and a store;
// then 48 MD4 rounds and a 64-bit restoring modulo.
// After reset or any register write a pass rebuilds the prefix counts; a write during
// the pass restarts it.
// The block takes no item while the prefix pass is due or runs, a chain runs or its result waits.
module ntlm_rainbow_chain_walker
  import ntlm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [79:0]         s_axis_tdata,  // charset_slot, charset_byte, start_index
  input  logic                s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // end_index
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  logic [8:0]  charset_size;
  logic [3:0]  min_length, max_length;
  logic [31:0] table_offset, chain_length;
  logic [7:0]  charset_store [CharsetDepth];
  logic [63:0] prefix [MaxText];
  logic [7:0]  text [MaxText];
  logic [63:0] space_total, cur, prod, h;
  logic [31:0] step_pos;
  logic [3:0]  len, cnt;
  logic [5:0]  rnd;
  logic [31:0] va, vb, vc, vd;
  logic [63:0] dq, dr;
  logic [63:0] rem;
  logic [6:0]  bitc;
  logic        need_space;
  logic [7:0]  rd_addr;
  logic [7:0]  rd_data;
  logic [3:0]  dig_pos;
  state_t      state, state_next;

  logic [8:0]  radix;
  logic [3:0]  lo_len, hi_len, lo0, cap;
  always_comb begin
    radix  = (charset_size == 9'd0) ? 9'd1 :
             (charset_size > 9'(CharsetDepth)) ? 9'(CharsetDepth) : charset_size;
    cap    = (MaxText - 1 > 27) ? 4'd15 : 4'(MaxText - 1);
    lo0    = (min_length == 4'd0) ? 4'd1 : min_length;
    if (lo0 > cap) lo0 = cap;
    hi_len = (max_length > cap) ? cap : max_length;
    if (hi_len < lo0) hi_len = lo0;
    lo_len = lo0;
  end

  // accept
  logic acc;
  assign s_axis_tready = (state == ST_IDLE) && !need_space && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;

  // one restoring division step shared by digits and modulo
  logic [64:0] trial;
  logic [63:0] divisor;
  assign divisor = (state == ST_MOD) ? space_total : {55'd0, radix};
  assign trial = {rem, dq[63]} - {1'b0, divisor};

  // MD4 round unit
  logic [31:0] mw [16];
  logic [31:0] f, x, sum, rot;
  logic [3:0]  wi;
  logic [4:0]  sh;
  always_comb begin
    for (int i = 0; i < 16; i++) mw[i] = 32'd0;
    for (int i = 0; i < MaxText / 2; i++) begin
      if (4'(2 * i + 1) < len) mw[i] = {8'd0, text[2*i+1], 8'd0, text[2*i]};
    end
    if (len[0]) mw[len >> 1] = {8'd0, 8'h80, 8'd0, text[len - 4'd1]};
    else mw[len >> 1] = 32'h80;
    mw[14] = {24'd0, len, 4'd0};
    wi = msg_word(rnd);
    sh = rot_amt(rnd);
    if (rnd < 6'd16) begin
      f = vd ^ (vb & (vc ^ vd)); x = mw[wi];
    end else if (rnd < 6'd32) begin
      f = (vb & (vc | vd)) | (vc & vd); x = mw[wi] + K2;
    end else begin
      f = vb ^ vc ^ vd; x = mw[wi] + K3;
    end
    sum = va + f + x;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_LOAD)
      charset_store[s_axis_tdata[7:0]] <= s_axis_tdata[15:8];
    rd_data <= charset_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      charset_size <= 9'd26; min_length <= 4'd1; max_length <= 4'd7;
      table_offset <= 32'd0; chain_length <= 32'd1000;
      need_space <= 1'b1; m_axis_tvalid <= 1'b0;
      space_total <= 64'd0; cur <= 64'd0; step_pos <= 32'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHARSET_SIZE: charset_size <= cfg_data[8:0];
          REG_MIN_LENGTH:   min_length <= cfg_data[3:0];
          REG_MAX_LENGTH:   max_length <= cfg_data[3:0];
          REG_TABLE_OFFSET: table_offset <= cfg_data;
          REG_CHAIN_LENGTH: chain_length <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_CHAIN_LENGTH) need_space <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (need_space && !cfg_we) begin
            prefix[0] <= 64'd0; prod <= 64'd1; cnt <= 4'd1;
          end else if (acc && s_axis_tuser == ACT_WALK) begin
            cur <= s_axis_tdata[79:16]; step_pos <= 32'd0;
          end
        end
        ST_SPACE: begin
          logic [72:0] p;
          logic [63:0] n, ps;
          p = prod * radix;
          n = (p[72:64] != 9'd0) ? '1 : p[63:0];
          ps = prefix[cnt - 4'd1] + n;
          if (!cfg_we) begin
            prod <= n;
            if (cnt < lo_len) prefix[cnt] <= 64'd0;
            else prefix[cnt] <= (ps < n) ? '1 : ps;
            cnt <= cnt + 4'd1;
            if (cnt == hi_len) begin
              space_total <= (ps < n) ? '1 : ps;
              if (cnt < lo_len) space_total <= 64'd0;
              need_space <= 1'b0;
            end
          end
        end
        ST_STEP: begin
          cnt <= hi_len; len <= lo_len;
        end
        ST_LEN: begin
          if (cur >= prefix[cnt - 4'd1]) begin
            len <= cnt;
            dq  <= cur - prefix[cnt - 4'd1];
            dig_pos <= cnt - 4'd1;
          end else begin
            cnt <= cnt - 4'd1;
            if (cnt == lo_len) begin
              len <= lo_len; dq <= cur - prefix[lo_len - 4'd1];
              dig_pos <= lo_len - 4'd1;
            end
          end
          rem <= 64'd0; bitc <= 7'd0;
        end
        ST_DIGIT: begin
          if (bitc < 7'd64) begin
            if (!trial[64]) begin
              rem <= trial[63:0]; dq <= {dq[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], dq[63]}; dq <= {dq[62:0], 1'b0};
            end
            bitc <= bitc + 7'd1;
          end else begin
            bitc <= 7'd65;
          end
        end
        ST_TEXT: begin
          text[dig_pos] <= rd_data;
          dig_pos <= dig_pos - 4'd1;
          rem <= 64'd0; bitc <= 7'd0;
          va <= IV0; vb <= IV1; vc <= IV2; vd <= IV3; rnd <= 6'd0;
        end
        ST_ROUND: begin
          va <= vd; vb <= rot; vc <= vb; vd <= vc;
          rnd <= rnd + 6'd1;
        end
        ST_SUM: begin
          h <= {vb + IV1, va + IV0} + {32'd0, table_offset} + {32'd0, step_pos};
          rem <= 64'd0; bitc <= 7'd0;
        end
        ST_MOD: begin
          if (bitc == 7'd0) dq <= h;
          if (bitc != 7'd0) begin
            if (!trial[64]) rem <= trial[63:0];
            else rem <= {rem[62:0], dq[63]};
            dq <= {dq[62:0], 1'b0};
          end
          bitc <= bitc + 7'd1;
          if (bitc == 7'd64) begin
            step_pos <= step_pos + 32'd1;
          end
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
      if (state == ST_MOD && bitc == 7'd65)
        cur <= (space_total == 64'd0) ? 64'd0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) m_axis_tdata <= cur;
  end

  logic [31:0] steps;
  assign steps = (chain_length == 32'd0) ? 32'd0 : chain_length - 32'd1;

  always_comb begin
    state_next = state;
    rd_addr = rem[7:0];
    unique case (state)
      ST_IDLE:
        if (need_space && !cfg_we) state_next = ST_SPACE;
        else if (acc && s_axis_tuser == ACT_WALK) state_next = ST_STEP;
      ST_SPACE: if (cfg_we || cnt == hi_len) state_next = ST_IDLE;
      ST_STEP:  state_next = (step_pos == steps) ? ST_OUT : ST_LEN;
      ST_LEN:
        if (cur >= prefix[cnt - 4'd1] || cnt == lo_len) state_next = ST_DIGIT;
      ST_DIGIT: if (bitc == 7'd65) state_next = ST_TEXT;
      ST_TEXT:  state_next = (dig_pos == 4'd0) ? ST_ROUND : ST_DIGIT;
      ST_ROUND: if (rnd == 6'd47) state_next = ST_SUM;
      ST_SUM:   state_next = ST_MOD;
      ST_MOD:   if (bitc == 7'd65) state_next = ST_STEP;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    if (state == ST_DIGIT && bitc == 7'd64) rd_addr = rem[7:0];
  end

  // The digit remainder used as charset address is below the radix.
  a_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEXT) |-> ({1'b0, rem} < {1'b0, 55'd0, radix}))
    else $error("digit out of radix");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accepting while result pending");
  a_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && space_total != 64'd0 && $past(state) == ST_MOD) |->
    (cur < space_total))
    else $error("index beyond space");
endmodule
